>>> hw/rtl/fsra_pkg.sv
// Shared types and constants for the fit-strategy region allocator.
package fsra_pkg;

    localparam int FIELD_BITS     = 16;
    localparam int COUNT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [15:0] MEM_SIZE_RESET = 16'd4096;

    typedef enum logic [1:0] {
        REQ_RESTART = 2'd0,
        REQ_BLOCK   = 2'd1,
        REQ_ALLOC   = 2'd2,
        REQ_NOP     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2
    } alloc_mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ALLOC_MODE = 1'd0,
        CFG_MEM_SIZE   = 1'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        CELL_KEEP,
        CELL_LOAD,
        CELL_CLEAR,
        CELL_TRIM,
        CELL_CUT_LOW,
        CELL_TAKE_TAIL,
        CELL_TAKE_LOWER,
        CELL_TAKE_PAGE,
        CELL_COMPACT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     lower_live;
        logic     upper_live;
    } cell_ctl_t;

endpackage

>>> hw/rtl/fit_strategy_region_allocator.sv
// Top level of the fit-strategy region allocator: sequencer over a row of range cells.
//
//  Channel | Signals                                          | Transfer when
//  cfg     | cfg_index, cfg_data                              | cfg_valid & cfg_ready
//  in      | req_type, region_start, region_end, page_size    | in_valid & in_ready
//  out     | status, alloc_start, alloc_end, free_ranges      | out_valid & out_ready
//
// in_ready is high only in IDLE, right after reset too; one item is in work at a time.
// No-op, empty-region, refused and zero-page items go from EXEC straight to FINISH.
// Restart and block add COMPACT, which shifts live ranges down until no gap is left.
// Allocate scans one cell per cycle in SCAN: no fit goes on to FINISH, a fit goes
// through APPLY and then COMPACT, which shifts the ranges down when one empties.
// The next transfer can come while the result is shown; a stalled output holds only FINISH.
module fit_strategy_region_allocator #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fsra_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fsra_pkg::FIELD_BITS-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            req_type,
    input  logic [fsra_pkg::FIELD_BITS-1:0]       region_start,
    input  logic [fsra_pkg::FIELD_BITS-1:0]       region_end,
    input  logic [fsra_pkg::FIELD_BITS-1:0]       page_size,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic [fsra_pkg::FIELD_BITS-1:0]       alloc_start,
    output logic [fsra_pkg::FIELD_BITS-1:0]       alloc_end,
    output logic [fsra_pkg::COUNT_BITS-1:0]       free_ranges
);
    import fsra_pkg::*;

    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_APPLY   = 6'b001000,
        S_COMPACT = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             req_reg, req_next;
    logic [ADDR_BITS-1:0]   start_reg, start_next;
    logic [ADDR_BITS-1:0]   end_reg, end_next;
    logic [ADDR_BITS-1:0]   page_reg, page_next;
    logic [1:0]             mode_reg, mode_next;
    logic [15:0]            mem_size_reg, mem_size_next;
    logic [IDX_BITS-1:0]    scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_BITS-1:0]    pick_reg, pick_next;
    logic [ADDR_BITS-1:0]   best_len_reg, best_len_next;
    logic [ADDR_BITS-1:0]   best_base_reg, best_base_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0]   res_start_reg, res_start_next;
    logic [ADDR_BITS-1:0]   res_end_reg, res_end_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0]   out_start_reg, out_start_next;
    logic [ADDR_BITS-1:0]   out_end_reg, out_end_next;
    logic [COUNT_BITS-1:0]  out_count_reg, out_count_next;

    logic [ADDR_BITS-1:0]   cell_base [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0]   cell_len [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] cell_live, cell_split;
    cell_ctl_t              cell_ctl [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0]   mem_size_cut;

    logic                   split_any, gap_any, region_ok, refuse;
    logic [IDX_BITS-1:0]    split_idx;
    logic [CNT_BITS-1:0]    live_count;
    logic                   rd_fits, take;
    logic                   in_xfer, out_free;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign in_xfer      = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign mem_size_cut = ADDR_BITS'(mem_size_reg);
    assign region_ok    = (end_reg > start_reg);
    assign refuse       = split_any && cell_live[TABLE_ENTRIES-1];

    // Row of range cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        logic [ADDR_BITS-1:0] lo_base, lo_len, up_base, up_len;
        if (g == 0)
        begin : g_first
            assign lo_base = '0;
            assign lo_len  = '0;
        end
        else
        begin : g_lower
            assign lo_base = cell_base[g-1];
            assign lo_len  = cell_len[g-1];
        end
        if (g == TABLE_ENTRIES - 1)
        begin : g_last
            assign up_base = '0;
            assign up_len  = '0;
        end
        else
        begin : g_upper
            assign up_base = cell_base[g+1];
            assign up_len  = cell_len[g+1];
        end
        fsra_cell #(
            .ADDR_BITS (ADDR_BITS),
            .HEAD      (g == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[g]),
            .reg_start  (start_reg),
            .reg_end    (end_reg),
            .page       (page_reg),
            .mem_size   (mem_size_cut),
            .lower_base (lo_base),
            .lower_len  (lo_len),
            .upper_base (up_base),
            .upper_len  (up_len),
            .base       (cell_base[g]),
            .len        (cell_len[g]),
            .live       (cell_live[g]),
            .split      (cell_split[g])
        );
    end

    // Reduce per-cell flags: split position, gaps and live count
    always_comb
    begin
        split_any  = |cell_split;
        split_idx  = '0;
        gap_any    = 1'b0;
        live_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (cell_split[i])
            begin
                split_idx = split_idx | IDX_BITS'(i);
            end
            if (i < TABLE_ENTRIES - 1)
            begin
                if (!cell_live[i] && cell_live[i+1])
                begin
                    gap_any = 1'b1;
                end
                if (cell_live[i] && !cell_live[i+1])
                begin
                    live_count = live_count | CNT_BITS'(i + 1);
                end
            end
            else if (cell_live[i])
            begin
                live_count = live_count | CNT_BITS'(i + 1);
            end
        end
    end

    // Drive each cell's command
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            cell_ctl[i].op         = CELL_KEEP;
            cell_ctl[i].lower_live = (i == 0) ? 1'b1 : cell_live[(i == 0) ? 0 : i-1];
            cell_ctl[i].upper_live = (i == TABLE_ENTRIES - 1) ? 1'b0 :
                                     cell_live[(i == TABLE_ENTRIES - 1) ? i : i+1];
            unique case (state_reg)
                S_EXEC:
                begin
                    if (req_reg == REQ_RESTART)
                    begin
                        cell_ctl[i].op = (i == 0) ? CELL_LOAD : CELL_CLEAR;
                    end
                    else if (req_reg == REQ_BLOCK && region_ok && !refuse)
                    begin
                        if (!split_any)
                        begin
                            cell_ctl[i].op = CELL_TRIM;
                        end
                        else if ((IDX_BITS+1)'(i) == {1'b0, split_idx})
                        begin
                            cell_ctl[i].op = CELL_CUT_LOW;
                        end
                        else if ((IDX_BITS+1)'(i) == {1'b0, split_idx} + 1'b1)
                        begin
                            cell_ctl[i].op = CELL_TAKE_TAIL;
                        end
                        else if ((IDX_BITS+1)'(i) > {1'b0, split_idx} + 1'b1)
                        begin
                            cell_ctl[i].op = CELL_TAKE_LOWER;
                        end
                    end
                end
                S_APPLY:
                begin
                    if (IDX_BITS'(i) == pick_reg)
                    begin
                        cell_ctl[i].op = CELL_TAKE_PAGE;
                    end
                end
                S_COMPACT:
                begin
                    cell_ctl[i].op = CELL_COMPACT;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Scan compare: one cell per cycle against the best so far
    always_comb
    begin
        rd_fits = cell_live[scan_idx_reg] && (cell_len[scan_idx_reg] >= page_reg);
        unique case (mode_reg)
            MODE_BEST:  take = rd_fits && (!found_reg || cell_len[scan_idx_reg] < best_len_reg);
            MODE_WORST: take = rd_fits && (!found_reg || cell_len[scan_idx_reg] > best_len_reg);
            default:    take = rd_fits && !found_reg;
        endcase
    end

    // Sequencer, configuration and output register
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        page_next       = page_reg;
        mode_next       = mode_reg;
        mem_size_next   = mem_size_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_len_next   = best_len_reg;
        best_base_next  = best_base_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_count_next  = out_count_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALLOC_MODE: mode_next     = cfg_data[1:0];
                CFG_MEM_SIZE:   mem_size_next = cfg_data;
            endcase
        end

        // Drop the result once the far side takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next        = req_type;
                    start_next      = ADDR_BITS'(region_start);
                    end_next        = ADDR_BITS'(region_end);
                    page_next       = ADDR_BITS'(page_size);
                    res_status_next = ST_DONE;
                    res_start_next  = '0;
                    res_end_next    = '0;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (req_reg)
                    REQ_RESTART:
                    begin
                        state_next = S_COMPACT;
                    end
                    REQ_BLOCK:
                    begin
                        if (!region_ok)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (refuse)
                        begin
                            res_status_next = ST_REFUSED;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_COMPACT;
                        end
                    end
                    REQ_ALLOC:
                    begin
                        if (page_reg == '0)
                        begin
                            res_status_next = ST_NO_FIT;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            scan_idx_next = '0;
                            found_next    = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_next      = scan_idx_reg;
                    best_len_next  = cell_len[scan_idx_reg];
                    best_base_next = cell_base[scan_idx_reg];
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == IDX_BITS'(TABLE_ENTRIES - 1))
                begin
                    if (found_reg || take)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        res_status_next = ST_NO_FIT;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_APPLY:
            begin
                res_start_next = best_base_reg;
                res_end_next   = best_base_reg + page_reg - 1'b1;
                state_next     = S_COMPACT;
            end
            S_COMPACT:
            begin
                if (!gap_any)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_end_next    = res_end_reg;
                    out_count_next  = COUNT_BITS'(live_count);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            page_reg       <= '0;
            mode_reg       <= MODE_FIRST;
            mem_size_reg   <= MEM_SIZE_RESET;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            pick_reg       <= '0;
            best_len_reg   <= '0;
            best_base_reg  <= '0;
            res_status_reg <= ST_DONE;
            res_start_reg  <= '0;
            res_end_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_start_reg  <= '0;
            out_end_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            page_reg       <= page_next;
            mode_reg       <= mode_next;
            mem_size_reg   <= mem_size_next;
            scan_idx_reg   <= scan_idx_next;
            found_reg      <= found_next;
            pick_reg       <= pick_next;
            best_len_reg   <= best_len_next;
            best_base_reg  <= best_base_next;
            res_status_reg <= res_status_next;
            res_start_reg  <= res_start_next;
            res_end_reg    <= res_end_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_start_reg  <= out_start_next;
            out_end_reg    <= out_end_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign alloc_start = FIELD_BITS'(out_start_reg);
    assign alloc_end   = FIELD_BITS'(out_end_reg);
    assign free_ranges = out_count_reg;

endmodule

>>> hw/rtl/fsra_cell.sv
// One table cell: holds a free range and edits it from the command and its neighbors.
module fsra_cell #(
    parameter int ADDR_BITS = 16,
    parameter bit HEAD      = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fsra_pkg::cell_ctl_t   ctl,
    input  logic [ADDR_BITS-1:0]  reg_start,
    input  logic [ADDR_BITS-1:0]  reg_end,
    input  logic [ADDR_BITS-1:0]  page,
    input  logic [ADDR_BITS-1:0]  mem_size,
    input  logic [ADDR_BITS-1:0]  lower_base,
    input  logic [ADDR_BITS-1:0]  lower_len,
    input  logic [ADDR_BITS-1:0]  upper_base,
    input  logic [ADDR_BITS-1:0]  upper_len,
    output logic [ADDR_BITS-1:0]  base,
    output logic [ADDR_BITS-1:0]  len,
    output logic                  live,
    output logic                  split
);
    import fsra_pkg::*;

    localparam logic [ADDR_BITS-1:0] RESET_LEN = ADDR_BITS'(MEM_SIZE_RESET);

    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [ADDR_BITS-1:0] len_reg, len_next;
    logic                 live_reg, live_next;
    logic [ADDR_BITS:0]   top_addr, lower_top, s_ext, e_ext, b_ext;
    logic                 overlap;

    // Range bounds, one bit wider so the exclusive end never wraps
    assign b_ext     = {1'b0, base_reg};
    assign s_ext     = {1'b0, reg_start};
    assign e_ext     = {1'b0, reg_end};
    assign top_addr  = b_ext + {1'b0, len_reg};
    assign lower_top = {1'b0, lower_base} + {1'b0, lower_len};
    assign split     = live_reg && (s_ext > b_ext) && (e_ext < top_addr);
    assign overlap   = live_reg && (s_ext < top_addr) && (e_ext > b_ext);

    // Apply the command to this cell
    always_comb
    begin
        base_next = base_reg;
        len_next  = len_reg;
        live_next = live_reg;
        unique case (ctl.op)
            CELL_KEEP:
            begin
            end
            CELL_LOAD:
            begin
                base_next = '0;
                len_next  = mem_size;
                live_next = (mem_size != '0);
            end
            CELL_CLEAR:
            begin
                base_next = '0;
                len_next  = '0;
                live_next = 1'b0;
            end
            CELL_TRIM:
            begin
                if (overlap)
                begin
                    if (s_ext > b_ext)
                    begin
                        len_next = ADDR_BITS'(s_ext - b_ext);
                    end
                    else if (e_ext < top_addr)
                    begin
                        base_next = reg_end;
                        len_next  = ADDR_BITS'(top_addr - e_ext);
                    end
                    else
                    begin
                        live_next = 1'b0;
                    end
                end
            end
            CELL_CUT_LOW:
            begin
                len_next = ADDR_BITS'(s_ext - b_ext);
            end
            CELL_TAKE_TAIL:
            begin
                base_next = reg_end;
                len_next  = ADDR_BITS'(lower_top - e_ext);
                live_next = 1'b1;
            end
            CELL_TAKE_LOWER:
            begin
                base_next = lower_base;
                len_next  = lower_len;
                live_next = ctl.lower_live;
            end
            CELL_TAKE_PAGE:
            begin
                base_next = base_reg + page;
                len_next  = len_reg - page;
                live_next = (len_reg != page);
            end
            CELL_COMPACT:
            begin
                if (!live_reg && ctl.upper_live)
                begin
                    base_next = upper_base;
                    len_next  = upper_len;
                    live_next = 1'b1;
                end
                else if (live_reg && !ctl.lower_live)
                begin
                    live_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            len_reg  <= HEAD ? RESET_LEN : '0;
            live_reg <= HEAD && (RESET_LEN != '0);
        end
        else
        begin
            base_reg <= base_next;
            len_reg  <= len_next;
            live_reg <= live_next;
        end
    end

    assign base = base_reg;
    assign len  = len_reg;
    assign live = live_reg;

endmodule

>>> hw/rtl/fsra_checker.sv
// Port-level checks for the fit-strategy region allocator, bound to the top level.
module fsra_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [1:0]                            status,
    input logic [fsra_pkg::FIELD_BITS-1:0]       alloc_start,
    input logic [fsra_pkg::FIELD_BITS-1:0]       alloc_end,
    input logic [fsra_pkg::COUNT_BITS-1:0]       free_ranges
);
    import fsra_pkg::*;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(TABLE_ENTRIES);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(alloc_start) && $stable(alloc_end) && $stable(free_ranges))
        else $error("stalled result changed");

    // Addresses only accompany a successful allocation
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> alloc_start == '0 && alloc_end == '0)
        else $error("address reported without allocation");

    // Refuse only with a full table
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_REFUSED |-> free_ranges == FULL_COUNT)
        else $error("refusal with free table entries");

    // Go busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken back to back");

endmodule

bind fit_strategy_region_allocator fsra_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_fsra_checker (.*);

>>> dv/tb_fit_strategy_region_allocator.sv
// Testbench for the fit-strategy region allocator: directed table plus random traffic.
module tb_fit_strategy_region_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fsra_pkg::*;

    localparam int NUM_RANGES = 16;
    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] page;
    } request_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] first;
        logic [15:0] last;
        logic [4:0]  count;
    } grant_t;

    typedef struct {
        request_t req;
        logic     has_exp;
        grant_t   exp;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] req_type;
    logic [15:0] region_start;
    logic [15:0] region_end;
    logic [15:0] page_size;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [15:0] alloc_start;
    logic [15:0] alloc_end;
    logic [4:0] free_ranges;

    fit_strategy_region_allocator dut (.*);

    // Shadow of the free-range table and the registers
    logic [1:0]  mode_q;
    logic [15:0] size_q;
    logic [15:0] base_q [NUM_RANGES];
    logic [15:0] len_q [NUM_RANGES];
    int          live_q;

    grant_t pending_grants[$];
    int     mismatches = 0;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;
    int     quiet_cycles = 0;

    function automatic void table_restart();
        for (int i = 0; i < NUM_RANGES; i++)
        begin
            base_q[i] = '0;
            len_q[i] = '0;
        end
        live_q = 0;
        if (size_q != 0)
        begin
            len_q[0] = size_q;
            live_q = 1;
        end
    endfunction

    function automatic grant_t predict_grant(request_t r);
        grant_t g;
        logic [15:0] nb [NUM_RANGES];
        logic [15:0] nl [NUM_RANGES];
        int out_n;
        int pick;
        bit found;
        bit split;
        int b;
        int t;
        int s;
        int e;
        g = '0;
        s = int'(r.lo);
        e = int'(r.hi);
        case (r.kind)
            REQ_RESTART: table_restart();
            REQ_BLOCK:
            begin
                if (e > s)
                begin
                    split = 0;
                    for (int i = 0; i < live_q; i++)
                        if (s > int'(base_q[i]) && e < int'(base_q[i]) + int'(len_q[i]))
                            split = 1;
                    if (split && live_q >= NUM_RANGES)
                        g.st = ST_REFUSED;
                    else
                    begin
                        out_n = 0;
                        for (int i = 0; i < live_q; i++)
                        begin
                            b = int'(base_q[i]);
                            t = b + int'(len_q[i]);
                            if (s >= t || e <= b)
                            begin
                                nb[out_n] = 16'(b);
                                nl[out_n] = 16'(t - b);
                                out_n++;
                            end
                            else
                            begin
                                if (s > b && out_n < NUM_RANGES)
                                begin
                                    nb[out_n] = 16'(b);
                                    nl[out_n] = 16'(s - b);
                                    out_n++;
                                end
                                if (e < t && out_n < NUM_RANGES)
                                begin
                                    nb[out_n] = 16'(e);
                                    nl[out_n] = 16'(t - e);
                                    out_n++;
                                end
                            end
                        end
                        for (int i = 0; i < NUM_RANGES; i++)
                        begin
                            base_q[i] = i < out_n ? nb[i] : '0;
                            len_q[i] = i < out_n ? nl[i] : '0;
                        end
                        live_q = out_n;
                    end
                end
            end
            REQ_ALLOC:
            begin
                found = 0;
                pick = 0;
                if (r.page != 0)
                begin
                    for (int i = 0; i < live_q; i++)
                    begin
                        if (len_q[i] < r.page)
                            continue;
                        if (!found)
                        begin
                            pick = i;
                            found = 1;
                            if (mode_q != MODE_BEST && mode_q != MODE_WORST)
                                break;
                        end
                        else if (mode_q == MODE_BEST && len_q[i] < len_q[pick])
                            pick = i;
                        else if (mode_q == MODE_WORST && len_q[i] > len_q[pick])
                            pick = i;
                    end
                end
                if (!found)
                    g.st = ST_NO_FIT;
                else
                begin
                    g.first = base_q[pick];
                    g.last = base_q[pick] + r.page - 16'd1;
                    base_q[pick] = base_q[pick] + r.page;
                    len_q[pick] = len_q[pick] - r.page;
                    // Drop an emptied range and close the gap
                    if (len_q[pick] == 0)
                    begin
                        for (int i = pick; i < NUM_RANGES - 1; i++)
                        begin
                            base_q[i] = base_q[i + 1];
                            len_q[i] = len_q[i + 1];
                        end
                        base_q[NUM_RANGES - 1] = '0;
                        len_q[NUM_RANGES - 1] = '0;
                        live_q--;
                    end
                end
            end
            default: ;
        endcase
        g.count = 5'(live_q);
        return g;
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        grant_t got;
        grant_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, alloc_start, alloc_end, free_ranges};
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp = pending_grants.pop_front();
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d %h..%h n=%0d got st=%0d %h..%h n=%0d",
                            exp.st, exp.first, exp.last, exp.count,
                            got.st, got.first, got.last, got.count);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(request_t r, logic has_exp, grant_t exp);
        grant_t g;
        // Idle the sender for a random number of cycles
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.kind;
        region_start <= r.lo;
        region_end <= r.hi;
        page_size <= r.page;
        do
            @(posedge clk);
        while (!in_ready);
        g = predict_grant(r);
        if (has_exp)
            pending_grants.insert(pending_grants.size(), exp);
        else
            pending_grants.insert(pending_grants.size(), g);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        // Let the block settle before the next phase
        repeat (3 * NUM_RANGES + 10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_ALLOC_MODE)
            mode_q = val[1:0];
        else
            size_q = val;
    endtask

    function automatic request_t random_request();
        request_t r;
        int pick;
        int a;
        int w;
        r.lo = 16'($urandom);
        r.hi = 16'($urandom);
        r.page = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 4)
            r.kind = REQ_RESTART;
        else if (pick < 6)
            r.kind = REQ_NOP;
        else if (pick < 45)
        begin
            r.kind = REQ_BLOCK;
            // Mostly short holes inside the managed space
            if ($urandom_range(9) < 8)
            begin
                a = int'($urandom_range(size_q));
                w = int'($urandom_range(1, 64));
                r.lo = 16'(a);
                r.hi = (a + w > 65535) ? 16'hFFFF : 16'(a + w);
            end
        end
        else
        begin
            r.kind = REQ_ALLOC;
            if ($urandom_range(9) < 8)
                r.page = 16'($urandom_range(1, 128));
        end
        return r;
    endfunction

    table_row_t directed_rows[$];

    initial
    begin
        request_t r;
        int phase_mode[4] = '{0, 1, 2, 3};
        logic [15:0] phase_size[4] = '{16'd1, 16'd65535, 16'd300, 16'd4096};
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = CFG_ALLOC_MODE;
        cfg_data = '0;
        in_valid = 0;
        req_type = REQ_NOP;
        region_start = '0;
        region_end = '0;
        page_size = '0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mode_q = MODE_FIRST;
        size_q = MEM_SIZE_RESET;
        table_restart();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed rows: reset state, extremes, special cases
        directed_rows = '{
            '{'{REQ_ALLOC, 16'd0, 16'd0, 16'd16}, 1, '{ST_DONE, 16'd0, 16'd15, 5'd1}},
            '{'{REQ_ALLOC, 16'd0, 16'd0, 16'd0}, 1, '{ST_NO_FIT, 16'd0, 16'd0, 5'd1}},
            '{'{REQ_ALLOC, 16'd0, 16'd0, 16'hFFFF}, 1, '{ST_NO_FIT, 16'd0, 16'd0, 5'd1}},
            '{'{REQ_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{ST_DONE, 16'd0, 16'd0, 5'd1}},
            '{'{REQ_BLOCK, 16'd100, 16'd50, 16'd0}, 1, '{ST_DONE, 16'd0, 16'd0, 5'd1}},
            '{'{REQ_BLOCK, 16'd100, 16'd200, 16'd0}, 0, '0},
            '{'{REQ_BLOCK, 16'd0, 16'hFFFF, 16'd0}, 1, '{ST_DONE, 16'd0, 16'd0, 5'd0}},
            '{'{REQ_ALLOC, 16'd0, 16'd0, 16'd1}, 1, '{ST_NO_FIT, 16'd0, 16'd0, 5'd0}},
            '{'{REQ_RESTART, 16'd0, 16'd0, 16'd0}, 1, '{ST_DONE, 16'd0, 16'd0, 5'd1}},
            '{'{REQ_ALLOC, 16'd0, 16'd0, 16'd4096}, 1, '{ST_DONE, 16'd0, 16'd4095, 5'd0}},
            '{'{REQ_RESTART, 16'd0, 16'd0, 16'd0}, 0, '0}
        };
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_exp, directed_rows[i].exp);
        // Fill the table with holes, then try one more split
        for (int i = 0; i < 16; i++)
        begin
            r = '{REQ_BLOCK, 16'(i * 200 + 100), 16'(i * 200 + 110), 16'hFFFF};
            send_request(r, 0, '0);
        end
        drain();

        // Random phases through modes, sizes and idling profiles
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_ALLOC_MODE, 16'(phase_mode[p]));
            write_reg(CFG_MEM_SIZE, phase_size[p]);
            send_idle_pct = (p == 1 || p == 3) ? 86 : 0;
            recv_stall_pct = (p == 2) ? 86 : (p == 3 ? 86 : 0);
            if (p == 3)
            begin
                send_idle_pct = 14;
                recv_stall_pct = 14;
            end
            r = '{REQ_RESTART, 16'hFFFF, 16'h0000, 16'h0000};
            send_request(r, 0, '0);
            if (p == 0)
            begin
                // Long receiver hold-off while items keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            begin
                send_request(random_request(), 0, '0);
                // Pause the sender until everything is back
                if (i == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_grants.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && pending_grants.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
